// ===== rtl/core/mre_pkg.sv =====
// shared types and constants for the marker record extractor
package mre_pkg;

   localparam int WINDOW = 320;
   localparam int SIG_LEN = 8;
   localparam logic [63:0] SIG_VALUE = 64'h4550_4B47_0100_0000;
   localparam logic [30:0] VERSION_MAX = 31'h7FFF_FFFF;

   localparam int OFFSET_W = 9;
   localparam int COUNT_W = 9;
   localparam int CAP_W = 10;
   localparam int SEEN_W = 4;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   localparam logic KIND_NAME = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NO_SIG = 3'd1;
   localparam logic [2:0] ST_NO_TERM = 3'd2;
   localparam logic [2:0] ST_EMPTY_NAME = 3'd3;
   localparam logic [2:0] ST_BAD_VERSION = 3'd4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = 2;
   localparam int QUEUE_CW = 3;

   typedef enum logic [1:0] {
      PH_SEARCH,
      PH_NAME,
      PH_VERSION,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  name_byte;
      logic [8:0]  name_length;
      logic [30:0] version;
      logic [2:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic    name_push;
      logic    fin_push;
      rsp_type name_rsp;
      rsp_type fin_rsp;
   } push_type;

endpackage

// ===== rtl/core/marker_record_extractor.sv =====
// top level of the marker record extractor: input register, parser, result queue
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  req_data_byte, req_end_of_file
//  rsp      out        rsp_valid / rsp_stall  rsp_kind, rsp_name_byte, rsp_name_length,
//                                             rsp_version, rsp_status, rsp_last
//  csr      in         csr_write_enable       csr_write_data (name capacity)
//
// one byte beat per cycle sustained while req_stall stays low; the parser decodes the beat
// held in the input register and its results are written into the queue, whose head drives rsp
// a byte beat yields zero, one or two results; the four-entry queue holds them
// synchronous reset clears parser state and queue pointers, capacity goes to 64
// req_stall rises only when the queue has fewer than two free entries and a beat waits
module marker_record_extractor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_end_of_file,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_kind,
   output logic [7:0]                  rsp_name_byte,
   output logic [8:0]                  rsp_name_length,
   output logic [30:0]                 rsp_version,
   output logic [2:0]                  rsp_status,
   output logic                        rsp_last,
   input  logic                        csr_write_enable,
   input  logic [mre_pkg::CAP_W-1:0]   csr_write_data
);
   import mre_pkg::*;

   // input register
   logic req_valid_ff;
   logic [7:0] req_data_ff;
   logic req_eof_ff;
   logic [CAP_W-1:0] capacity_ff;

   logic room;
   logic go;
   push_type push;
   rsp_type head;

   // the held beat moves on only when the queue can absorb two results
   assign go = req_valid_ff && room;
   assign req_stall = req_valid_ff && !room;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_data_ff <= req_data_byte;
         req_eof_ff <= req_end_of_file;
      end
   end

   // name capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(64);
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

   mre_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .go            (go),
      .data_byte     (req_data_ff),
      .end_of_file   (req_eof_ff),
      .name_capacity (capacity_ff),
      .push          (push)
   );

   mre_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   // result fields straight from the queue head
   assign rsp_kind = head.kind;
   assign rsp_name_byte = head.name_byte;
   assign rsp_name_length = head.name_length;
   assign rsp_version = head.version;
   assign rsp_status = head.status;
   assign rsp_last = head.last;

endmodule

// ===== rtl/core/mre_parse.sv =====
// per-byte parser: signature search, name streaming and version decode
module mre_parse (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [7:0]                   data_byte,
   input  logic                         end_of_file,
   input  logic [mre_pkg::CAP_W-1:0]    name_capacity,
   output mre_pkg::push_type            push
);
   import mre_pkg::*;

   localparam logic [OFFSET_W-1:0] WINDOW_LIMIT = OFFSET_W'(WINDOW);
   localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(SIG_LEN);

   phase_type phase_ff, phase_in, phase_step;
   logic [63:0] recent_ff, recent_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [COUNT_W-1:0] kept_ff, kept_in;
   logic [30:0] ver_ff, ver_in;
   logic digit_seen_ff, digit_seen_in;
   logic digits_ended_ff, digits_ended_in;
   logic overflow_ff, overflow_in;
   logic name_empty_ff, name_empty_in;

   logic [COUNT_W-1:0] limit;
   logic [CAP_W-1:0] cap_minus;
   logic sig_match;
   logic in_window;
   logic is_digit;
   logic [34:0] ver_next;
   logic step_final;
   logic [2:0] step_status;
   logic name_push;
   logic [63:0] recent_shift;
   logic [SEEN_W-1:0] seen_inc;

   always_comb begin
      cap_minus = name_capacity - CAP_W'(1);
      if (name_capacity == '0) begin
         limit = '0;
      end else if (cap_minus[CAP_W-1]) begin
         limit = '1;
      end else begin
         limit = cap_minus[COUNT_W-1:0];
      end
   end

   assign recent_shift = {recent_ff[55:0], data_byte};
   assign seen_inc = (seen_ff < SEEN_FULL) ? seen_ff + SEEN_W'(1) : seen_ff;
   assign sig_match = (seen_inc == SEEN_FULL) && (recent_shift == SIG_VALUE);
   assign in_window = offset_ff < WINDOW_LIMIT;
   assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
   assign ver_next = {1'b0, ver_ff, 3'b000} + {3'b000, ver_ff, 1'b0}
      + {31'd0, 4'(data_byte - CHAR_ZERO)};

   // next phase: the byte's own effect, then end of file
   always_comb begin
      phase_step = phase_ff;
      case (phase_ff)
         PH_SEARCH: begin
            if (sig_match) begin
               phase_step = PH_NAME;
            end
         end
         PH_NAME: begin
            if (!in_window) begin
               phase_step = PH_DONE;
            end else if (data_byte == CHAR_NUL) begin
               phase_step = PH_VERSION;
            end
         end
         PH_VERSION: begin
            if (!in_window || data_byte == CHAR_NUL) begin
               phase_step = PH_DONE;
            end
         end
         default: begin
            phase_step = PH_DONE;
         end
      endcase
      phase_in = phase_ff;
      if (go) begin
         phase_in = end_of_file ? PH_SEARCH : phase_step;
      end
   end

   // outputs and datapath
   always_comb begin
      recent_in = recent_ff;
      seen_in = seen_ff;
      offset_in = offset_ff;
      kept_in = kept_ff;
      ver_in = ver_ff;
      digit_seen_in = digit_seen_ff;
      digits_ended_in = digits_ended_ff;
      overflow_in = overflow_ff;
      name_empty_in = name_empty_ff;
      step_final = 1'b0;
      step_status = ST_OK;
      name_push = 1'b0;

      case (phase_ff)
         PH_SEARCH: begin
            recent_in = recent_shift;
            seen_in = seen_inc;
            if (sig_match) begin
               offset_in = '0;
            end
         end
         PH_NAME: begin
            if (!in_window) begin
               step_final = 1'b1;
               step_status = ST_NO_TERM;
            end else begin
               offset_in = offset_ff + OFFSET_W'(1);
               if (data_byte == CHAR_NUL) begin
                  name_empty_in = (offset_ff == '0);
               end else if (kept_ff < limit) begin
                  name_push = 1'b1;
                  kept_in = kept_ff + COUNT_W'(1);
               end
            end
         end
         PH_VERSION: begin
            if (!in_window) begin
               step_final = 1'b1;
               step_status = ST_NO_TERM;
            end else begin
               offset_in = offset_ff + OFFSET_W'(1);
               if (data_byte == CHAR_NUL) begin
                  step_final = 1'b1;
                  if (name_empty_ff) begin
                     step_status = ST_EMPTY_NAME;
                  end else if (!digit_seen_ff || overflow_ff) begin
                     step_status = ST_BAD_VERSION;
                  end
               end else if (!digits_ended_ff && !overflow_ff) begin
                  if (is_digit) begin
                     digit_seen_in = 1'b1;
                     if (ver_next > {4'd0, VERSION_MAX}) begin
                        overflow_in = 1'b1;
                     end else begin
                        ver_in = ver_next[30:0];
                     end
                  end else begin
                     digits_ended_in = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      // end of file before any final of this file closes it out
      if (end_of_file && !step_final) begin
         if (phase_step == PH_SEARCH) begin
            step_final = 1'b1;
            step_status = ST_NO_SIG;
         end else if (phase_step == PH_NAME || phase_step == PH_VERSION) begin
            step_final = 1'b1;
            step_status = ST_NO_TERM;
         end
      end

      push.name_push = go && name_push;
      push.name_rsp.kind = KIND_NAME;
      push.name_rsp.name_byte = data_byte;
      push.name_rsp.name_length = '0;
      push.name_rsp.version = '0;
      push.name_rsp.status = ST_OK;
      push.name_rsp.last = 1'b0;

      push.fin_push = go && step_final;
      push.fin_rsp.kind = KIND_FINAL;
      push.fin_rsp.name_byte = '0;
      push.fin_rsp.name_length = kept_in;
      push.fin_rsp.version = (step_status == ST_OK) ? ver_ff : '0;
      push.fin_rsp.status = step_status;
      push.fin_rsp.last = 1'b1;

      if (end_of_file) begin
         recent_in = '0;
         seen_in = '0;
         offset_in = '0;
         kept_in = '0;
         ver_in = '0;
         digit_seen_in = 1'b0;
         digits_ended_in = 1'b0;
         overflow_in = 1'b0;
         name_empty_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         recent_ff <= '0;
         seen_ff <= '0;
         offset_ff <= '0;
         kept_ff <= '0;
         ver_ff <= '0;
         digit_seen_ff <= 1'b0;
         digits_ended_ff <= 1'b0;
         overflow_ff <= 1'b0;
         name_empty_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (go) begin
            recent_ff <= recent_in;
            seen_ff <= seen_in;
            offset_ff <= offset_in;
            kept_ff <= kept_in;
            ver_ff <= ver_in;
            digit_seen_ff <= digit_seen_in;
            digits_ended_ff <= digits_ended_in;
            overflow_ff <= overflow_in;
            name_empty_ff <= name_empty_in;
         end
      end
   end

endmodule

// ===== rtl/core/mre_rsp_queue.sv =====
// four-entry result queue taking up to two results per cycle
module mre_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  mre_pkg::push_type   push,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mre_pkg::rsp_type    head
);
   import mre_pkg::*;

   rsp_type entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;
   logic [QUEUE_AW-1:0] fin_idx;
   logic pop;

   assign room = count_ff <= QUEUE_CW'(QUEUE_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign pop = rsp_valid && !rsp_stall;
   assign head = entry_ff[rd_ptr_ff];
   assign fin_idx = wr_ptr_ff + QUEUE_AW'(push.name_push);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push.name_push) + QUEUE_AW'(push.fin_push);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(pop);
      count_in = count_ff + QUEUE_CW'(push.name_push) + QUEUE_CW'(push.fin_push)
         - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.name_push) begin
         entry_ff[wr_ptr_ff] <= push.name_rsp;
      end
      if (push.fin_push) begin
         entry_ff[fin_idx] <= push.fin_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/core/mre_checker.sv =====
// port-level checks on the result channel, bound to the top level
module mre_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_kind,
   input logic [7:0]  rsp_name_byte,
   input logic [8:0]  rsp_name_length,
   input logic [30:0] rsp_version,
   input logic [2:0]  rsp_status,
   input logic        rsp_last
);
   import mre_pkg::*;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_name_byte) && $stable(rsp_name_length)
         && $stable(rsp_version) && $stable(rsp_status) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   a_last_on_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last == (rsp_kind == KIND_FINAL))
      else $error("last flag does not match result kind");

   a_name_beat_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_NAME |->
         rsp_name_length == '0 && rsp_version == '0 && rsp_status == ST_OK)
      else $error("name beat carries final fields");

   a_version_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FINAL && rsp_status != ST_OK |->
         rsp_version == '0 && rsp_name_byte == '0)
      else $error("failed final carries a version");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_NO_SIG
         || rsp_status == ST_NO_TERM || rsp_status == ST_EMPTY_NAME
         || rsp_status == ST_BAD_VERSION)
      else $error("status code out of range");

endmodule

bind marker_record_extractor mre_checker u_mre_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_kind        (rsp_kind),
   .rsp_name_byte   (rsp_name_byte),
   .rsp_name_length (rsp_name_length),
   .rsp_version     (rsp_version),
   .rsp_status      (rsp_status),
   .rsp_last        (rsp_last)
);
